@@ src/swdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// swdpc_pkg
// Shared types, codes and constants for the switch debounce press classifier.
// ----------------------------------------------------------------------------
package swdpc_pkg;

  // Width of the sampled pin history
  localparam int HISTORY_BITS = 8;

  // Width of k * tick_ms products used to derive the press window
  localparam int PROD_W = 8 + $clog2(HISTORY_BITS + 1);

  // Configuration register widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICK_MS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_MS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_MS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_PATTERN  = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  TICK_MS_RST       = 8'd1;
  localparam logic [7:0]  PRESS_MS_RST      = 8'd50;
  localparam logic [15:0] LONG_PRESS_MS_RST = 16'd3000;
  localparam logic [7:0]  OPEN_PATTERN_RST  = 8'hFF;

  // Saturation limit for the held time
  localparam logic [15:0] HELD_MAX = 16'hFFFF;

  // Operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Debounce phases
  typedef enum logic [1:0] {
    PH_OPEN     = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2
  } phase_t;

  // Press classification codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } press_ev_t;

  // Configuration set handed to the core
  typedef struct packed {
    logic [7:0]  tick_ms;
    logic [7:0]  press_ms;
    logic [15:0] long_press_ms;
    logic [7:0]  open_pattern;
  } cfg_t;

endpackage

@@ src/swdpc_if.sv @@
// ----------------------------------------------------------------------------
// swdpc interfaces
// Valid/ready channels for input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface swdpc_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic pin_level;

  modport source (output valid, output operation, output pin_level, input ready);
  modport sink   (input valid, input operation, input pin_level, output ready);
endinterface

interface swdpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_event;

  modport source (output valid, output press_event, input ready);
  modport sink   (input valid, input press_event, output ready);
endinterface

interface swdpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swdpc_pkg::CFG_IDX_W-1:0]  index;
  logic [swdpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/swdpc_core.sv @@
// ----------------------------------------------------------------------------
// swdpc_core
// Debounce state: pin history, phase, held time and latched press event.
// Updates on each accepted transaction and returns that item's result.
// ----------------------------------------------------------------------------
module swdpc_core (
  input  logic                clk,
  input  logic                rst,
  input  swdpc_pkg::cfg_t     cfg,
  input  logic                step,
  input  logic                operation,
  input  logic                pin_level,
  output logic [1:0]          press_event
);

  localparam int HB = swdpc_pkg::HISTORY_BITS;
  localparam int PW = swdpc_pkg::PROD_W;

  logic [HB-1:0]        history, history_next;
  swdpc_pkg::phase_t    phase, phase_next;
  logic [15:0]          held_ms, held_ms_next;
  swdpc_pkg::press_ev_t latched, latched_next;

  logic [HB:0]   ge;
  logic [HB-1:0] mask;
  logic [HB-1:0] window;
  logic [HB-1:0] hist_shift;
  logic [HB-1:0] open_cmp;
  logic [16:0]   held_sum;

  // Press window: n = press_ms / tick_ms as a thermometer of n >= k compares
  always_comb begin
    for (int k = 0; k <= HB; k++) begin
      ge[k] = ({{(PW-8){1'b0}}, cfg.press_ms} >= (PW'(k) * {{(PW-8){1'b0}}, cfg.tick_ms}));
    end
    for (int k = 0; k < HB; k++) begin
      mask[k] = ge[k] & ~ge[k+1];
    end
  end

  assign window = mask | (mask - {{(HB-1){1'b0}}, 1'b1});

  // Open pattern restricted or zero-extended to the history width
  always_comb begin
    for (int i = 0; i < HB; i++) begin
      open_cmp[i] = (i < 8) ? cfg.open_pattern[i % 8] : 1'b0;
    end
  end

  assign hist_shift = {history[HB-2:0], pin_level};
  assign held_sum   = {1'b0, held_ms} + {9'd0, cfg.tick_ms};

  // Next state for one transaction
  always_comb begin
    history_next = history;
    phase_next   = phase;
    held_ms_next = held_ms;
    latched_next = latched;
    press_event  = swdpc_pkg::EV_NONE;
    if (operation == swdpc_pkg::OP_READ) begin
      press_event  = latched;
      latched_next = swdpc_pkg::EV_NONE;
    end else begin
      history_next = hist_shift;
      unique case (phase)
        swdpc_pkg::PH_OPEN: begin
          if ((hist_shift & window) == mask) begin
            phase_next   = swdpc_pkg::PH_PRESSED;
            held_ms_next = {8'd0, cfg.press_ms};
            history_next = '0;
          end
        end
        swdpc_pkg::PH_PRESSED: begin
          if (hist_shift == '0) begin
            held_ms_next = held_sum[16] ? swdpc_pkg::HELD_MAX : held_sum[15:0];
          end else begin
            phase_next   = swdpc_pkg::PH_RELEASED;
            latched_next = (held_ms >= cfg.long_press_ms) ? swdpc_pkg::EV_LONG
                                                          : swdpc_pkg::EV_SHORT;
            held_ms_next = '0;
          end
        end
        swdpc_pkg::PH_RELEASED: begin
          if (hist_shift == open_cmp) begin
            phase_next = swdpc_pkg::PH_OPEN;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '1;
      phase   <= swdpc_pkg::PH_OPEN;
      held_ms <= '0;
      latched <= swdpc_pkg::EV_NONE;
    end else if (step) begin
      history <= history_next;
      phase   <= phase_next;
      held_ms <= held_ms_next;
      latched <= latched_next;
    end
  end

endmodule

@@ src/switch_debounce_press_classifier.sv @@
// ----------------------------------------------------------------------------
// switch_debounce_press_classifier
// Active-low switch debouncer that classifies presses as short or long.
//
//   Channel  Dir  Payload                         Notes
//   in_ch    in   operation, pin_level            tick or read-and-clear
//   out_ch   out  press_event                     one result per input item
//   cfg      in   index, data                     always ready
//
// One item per cycle; each result appears in the output register the cycle
// after its transaction. State updates at acceptance, so the next item sees it.
// Input is ready whenever the output register is empty or being drained.
// Synchronous reset restores history all ones, phase open, default registers.
// ----------------------------------------------------------------------------
module switch_debounce_press_classifier (
  input logic          clk,
  input logic          rst,
  swdpc_in_if.sink     in_ch,
  swdpc_out_if.source  out_ch,
  swdpc_cfg_if.sink    cfg
);

  swdpc_pkg::cfg_t cfg_regs;
  logic            in_fire;
  logic [1:0]      core_event;
  logic            out_valid;
  logic [1:0]      out_event;

  // Configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.tick_ms       <= swdpc_pkg::TICK_MS_RST;
      cfg_regs.press_ms      <= swdpc_pkg::PRESS_MS_RST;
      cfg_regs.long_press_ms <= swdpc_pkg::LONG_PRESS_MS_RST;
      cfg_regs.open_pattern  <= swdpc_pkg::OPEN_PATTERN_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        swdpc_pkg::REG_TICK_MS:       cfg_regs.tick_ms       <= cfg.data[7:0];
        swdpc_pkg::REG_PRESS_MS:      cfg_regs.press_ms      <= cfg.data[7:0];
        swdpc_pkg::REG_LONG_PRESS_MS: cfg_regs.long_press_ms <= cfg.data;
        swdpc_pkg::REG_OPEN_PATTERN:  cfg_regs.open_pattern  <= cfg.data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input handshake
  assign in_ch.ready = ~out_valid | out_ch.ready;
  assign in_fire     = in_ch.valid & in_ch.ready;

  swdpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_regs),
    .step        (in_fire),
    .operation   (in_ch.operation),
    .pin_level   (in_ch.pin_level),
    .press_event (core_event)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_event <= core_event;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.press_event = out_event;

endmodule
